// ===== design/bfsa_pkg.sv =====
// shared types and constants of the best-fit segment allocator
// no dependencies
package bfsa_pkg;

    localparam int FREE_N   = 32;
    localparam int USED_N   = 32;
    localparam int PASS_LEN = (FREE_N > USED_N) ? FREE_N : USED_N;
    localparam int CNT_W    = $clog2(PASS_LEN);
    localparam int AW       = 12;

    localparam logic [AW-1:0] POOL_RESET = 12'd2000;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_NOUSED = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic REG_POOL_SIZE  = 1'b0;
    localparam logic REG_COMPACTION = 1'b1;

    typedef struct packed {
        logic          valid;
        logic          done;
        logic [AW-1:0] addr;
        logic [AW-1:0] size;
    } bfsa_entry_t;

    typedef struct packed {
        logic          mode;
        logic [AW-1:0] size;
    } bfsa_in_t;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] address;
        logic          compacted;
    } bfsa_out_t;

endpackage

// ===== design/best_fit_segment_allocator_core.sv =====
// top level of the best-fit segment allocator: sequencer around two rotating cell rings
// depends on bfsa_pkg, bfsa_free_ring, bfsa_used_ring
//
// Input channel s_valid/s_ready/s_data carries one request (mode, size); the result
// channel m_valid/m_ready/m_data returns one transaction (status, address, compacted)
// per request. Both tables live in rings of 32 cells that rotate one place a cycle while
// a pass runs; the sequencer sees and rewrites only the head cell, so every pass over a
// table visits each of its 32 cells once. Passes per request:
//   allocate of size zero: none
//   allocate: a scan pass, plus a write pass when a segment fits
//   allocate with packing: scan, one pass per used block plus one, final write pass
//   release: used scan pass, free scan pass, write pass
// One request is worked on at a time; s_ready is high only while the sequencer is
// idle. The result register holds a finished transaction while m_ready is low, and
// the next request may already be accepted and worked on; it waits at its end until
// the register is free. After reset, and after every write of pool_size, a pass rebuilds
// both tables (one free segment over the pool, no used block) with s_ready low.
// Configuration port: cfg_we, cfg_index, cfg_wdata, no read-back.
module best_fit_segment_allocator_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bfsa_pkg::bfsa_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bfsa_pkg::bfsa_out_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [11:0]         cfg_wdata
);

    localparam int AW = bfsa_pkg::AW;
    localparam int CW = bfsa_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_AL_SCAN, S_AL_WRITE, S_CP_SCAN, S_CP_FINAL,
        S_RL_USED, S_RL_FREE, S_RL_WRITE, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] pool_reg, pool_next;
    logic          comp_en_reg, comp_en_next;
    logic          m_valid_reg, m_valid_next;
    bfsa_pkg::bfsa_out_t m_data_reg, m_data_next;

    logic [AW-1:0] t_reg, t_next;
    logic          best_found_reg, best_found_next;
    logic [AW-1:0] best_size_reg, best_size_next;
    logic [AW-1:0] best_addr_reg, best_addr_next;
    logic          slot_reg, slot_next;
    logic          wrote_reg, wrote_next;
    logic          pick_found_reg, pick_found_next;
    logic [AW-1:0] pick_addr_reg, pick_addr_next;
    logic          nxt_found_reg, nxt_found_next;
    logic [AW-1:0] nxt_addr_reg, nxt_addr_next;
    logic [AW:0]   cursor_reg, cursor_next;
    logic          first_reg, first_next;
    logic          a_found_reg, a_found_next;
    logic [AW-1:0] a_reg, a_next;
    logic          left_reg, left_next;
    logic          right_reg, right_next;
    logic [AW-1:0] rsize_reg, rsize_next;
    logic [1:0]    status_reg, status_next;
    logic [AW-1:0] raddr_reg, raddr_next;
    logic          comp_reg, comp_next;

    bfsa_pkg::bfsa_entry_t fh, uh, f_wr, u_wr;
    logic pass, f_act, u_act, last;

    bfsa_free_ring u_free (
        .aclk(aclk), .shift_en(pass && f_act), .tail_d(f_wr), .head_q(fh)
    );
    bfsa_used_ring u_used (
        .aclk(aclk), .shift_en(pass && u_act), .tail_d(u_wr), .head_q(uh)
    );

    assign pass  = (state_reg != S_IDLE) && (state_reg != S_FIN);
    assign f_act = {1'b0, cnt_reg} < (CW+1)'(bfsa_pkg::FREE_N);
    assign u_act = {1'b0, cnt_reg} < (CW+1)'(bfsa_pkg::USED_N);
    assign last  = cnt_reg == CW'(bfsa_pkg::PASS_LEN - 1);

    always_comb begin
        logic [AW:0]   fh_end;
        logic [AW:0]   rel_end;
        logic [AW:0]   seg_size;
        logic          fits;
        logic          done_eff;
        bfsa_pkg::bfsa_entry_t e;

        state_next      = state_reg;
        cnt_next        = cnt_reg + CW'(1);
        pool_next       = pool_reg;
        comp_en_next    = comp_en_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        t_next          = t_reg;
        best_found_next = best_found_reg;
        best_size_next  = best_size_reg;
        best_addr_next  = best_addr_reg;
        slot_next       = slot_reg;
        wrote_next      = wrote_reg;
        pick_found_next = pick_found_reg;
        pick_addr_next  = pick_addr_reg;
        nxt_found_next  = nxt_found_reg;
        nxt_addr_next   = nxt_addr_reg;
        cursor_next     = cursor_reg;
        first_next      = first_reg;
        a_found_next    = a_found_reg;
        a_next          = a_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        rsize_next      = rsize_reg;
        status_next     = status_reg;
        raddr_next      = raddr_reg;
        comp_next       = comp_reg;
        f_wr            = fh;
        u_wr            = uh;
        e               = uh;
        done_eff        = 1'b0;

        fh_end   = {1'b0, fh.addr} + {1'b0, fh.size};
        rel_end  = {1'b0, a_reg} + {1'b0, t_reg};
        seg_size = {1'b0, pool_reg} - cursor_reg;
        fits     = (cursor_reg < {1'b0, pool_reg}) && (seg_size >= {1'b0, t_reg});

        case (state_reg)
            S_INIT: begin
                f_wr = '0;
                u_wr = '0;
                if (cnt_reg == '0 && pool_reg != '0) begin
                    f_wr.valid = 1'b1;
                    f_wr.size  = pool_reg;
                end
                if (last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    t_next          = s_data.size;
                    best_found_next = 1'b0;
                    slot_next       = 1'b0;
                    wrote_next      = 1'b0;
                    a_found_next    = 1'b0;
                    left_next       = 1'b0;
                    right_next      = 1'b0;
                    comp_next       = 1'b0;
                    raddr_next      = '0;
                    status_next     = bfsa_pkg::ST_OK;
                    if (s_data.mode == bfsa_pkg::MODE_RELEASE) begin
                        state_next = S_RL_USED;
                    end else if (s_data.size == '0) begin
                        status_next = bfsa_pkg::ST_NOFIT;
                        state_next  = S_FIN;
                    end else begin
                        state_next = S_AL_SCAN;
                    end
                end
            end
            S_AL_SCAN: begin
                if (u_act && !uh.valid) begin
                    slot_next = 1'b1;
                end
                if (f_act && fh.valid && fh.size >= t_reg &&
                    (!best_found_reg || fh.size < best_size_reg ||
                     (fh.size == best_size_reg && fh.addr < best_addr_reg))) begin
                    best_found_next = 1'b1;
                    best_size_next  = fh.size;
                    best_addr_next  = fh.addr;
                end
                if (last) begin
                    cnt_next = '0;
                    if (!slot_next) begin
                        status_next = bfsa_pkg::ST_FULL;
                        state_next  = S_FIN;
                    end else if (best_found_next) begin
                        state_next = S_AL_WRITE;
                    end else if (comp_en_reg) begin
                        comp_next       = 1'b1;
                        pick_found_next = 1'b0;
                        nxt_found_next  = 1'b0;
                        first_next      = 1'b1;
                        cursor_next     = '0;
                        state_next      = S_CP_SCAN;
                    end else begin
                        status_next = bfsa_pkg::ST_NOFIT;
                        state_next  = S_FIN;
                    end
                end
            end
            S_AL_WRITE: begin
                if (fh.valid && fh.addr == best_addr_reg) begin
                    f_wr.addr  = fh.addr + t_reg;
                    f_wr.size  = fh.size - t_reg;
                    f_wr.valid = fh.size != t_reg;
                end
                if (u_act && !uh.valid && !wrote_reg) begin
                    u_wr       = '{valid: 1'b1, done: 1'b0, addr: best_addr_reg, size: t_reg};
                    wrote_next = 1'b1;
                end
                if (last) begin
                    cnt_next    = '0;
                    raddr_next  = best_addr_reg;
                    state_next  = S_FIN;
                end
            end
            S_CP_SCAN: begin
                if (u_act) begin
                    done_eff = first_reg ? 1'b0 : uh.done;
                    e.done   = done_eff;
                    if (uh.valid && !done_eff) begin
                        if (pick_found_reg && uh.addr == pick_addr_reg) begin
                            e.addr      = cursor_reg[AW-1:0];
                            e.done      = 1'b1;
                            cursor_next = cursor_reg + {1'b0, uh.size};
                        end else if (!nxt_found_reg || uh.addr < nxt_addr_reg) begin
                            nxt_found_next = 1'b1;
                            nxt_addr_next  = uh.addr;
                        end
                    end
                    u_wr = e;
                end
                if (last) begin
                    cnt_next   = '0;
                    first_next = 1'b0;
                    if (nxt_found_next) begin
                        pick_found_next = 1'b1;
                        pick_addr_next  = nxt_addr_next;
                        nxt_found_next  = 1'b0;
                    end else begin
                        wrote_next = 1'b0;
                        state_next = S_CP_FINAL;
                    end
                end
            end
            S_CP_FINAL: begin
                f_wr = '0;
                if (cnt_reg == '0 && cursor_reg < {1'b0, pool_reg}) begin
                    if (fits) begin
                        f_wr.addr  = cursor_reg[AW-1:0] + t_reg;
                        f_wr.size  = seg_size[AW-1:0] - t_reg;
                        f_wr.valid = seg_size[AW-1:0] != t_reg;
                    end else begin
                        f_wr.addr  = cursor_reg[AW-1:0];
                        f_wr.size  = seg_size[AW-1:0];
                        f_wr.valid = 1'b1;
                    end
                end
                if (fits && u_act && !uh.valid && !wrote_reg) begin
                    u_wr = '{valid: 1'b1, done: 1'b0, addr: cursor_reg[AW-1:0], size: t_reg};
                    wrote_next = 1'b1;
                end
                if (last) begin
                    cnt_next    = '0;
                    status_next = fits ? bfsa_pkg::ST_OK : bfsa_pkg::ST_NOFIT;
                    raddr_next  = fits ? cursor_reg[AW-1:0] : '0;
                    state_next  = S_FIN;
                end
            end
            S_RL_USED: begin
                if (u_act && uh.valid && uh.size == t_reg &&
                    (!a_found_reg || uh.addr < a_reg)) begin
                    a_found_next = 1'b1;
                    a_next       = uh.addr;
                end
                if (last) begin
                    cnt_next = '0;
                    slot_next = 1'b0;
                    if (a_found_next) begin
                        state_next = S_RL_FREE;
                    end else begin
                        status_next = bfsa_pkg::ST_NOUSED;
                        state_next  = S_FIN;
                    end
                end
            end
            S_RL_FREE: begin
                if (f_act) begin
                    if (!fh.valid) begin
                        slot_next = 1'b1;
                    end else if (fh_end == {1'b0, a_reg}) begin
                        left_next = 1'b1;
                    end else if ({1'b0, fh.addr} == rel_end) begin
                        right_next = 1'b1;
                        rsize_next = fh.size;
                    end
                end
                if (last) begin
                    cnt_next = '0;
                    if (!left_next && !right_next && !slot_next) begin
                        status_next = bfsa_pkg::ST_FULL;
                        state_next  = S_FIN;
                    end else begin
                        state_next = S_RL_WRITE;
                    end
                end
            end
            S_RL_WRITE: begin
                if (f_act) begin
                    if (fh.valid) begin
                        if (left_reg && fh_end == {1'b0, a_reg}) begin
                            f_wr.size = fh.size + t_reg + (right_reg ? rsize_reg : '0);
                        end else if (left_reg && right_reg && {1'b0, fh.addr} == rel_end) begin
                            f_wr.valid = 1'b0;
                        end else if (!left_reg && right_reg && {1'b0, fh.addr} == rel_end) begin
                            f_wr.addr = a_reg;
                            f_wr.size = fh.size + t_reg;
                        end
                    end else if (!left_reg && !right_reg && !wrote_reg) begin
                        f_wr       = '{valid: 1'b1, done: 1'b0, addr: a_reg, size: t_reg};
                        wrote_next = 1'b1;
                    end
                end
                if (u_act && uh.valid && uh.addr == a_reg) begin
                    u_wr.valid = 1'b0;
                end
                if (last) begin
                    cnt_next   = '0;
                    raddr_next = a_reg;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cnt_next = '0;
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: status_reg, address: raddr_reg,
                                     compacted: comp_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
                cnt_next   = '0;
            end
        endcase

        if (cfg_we) begin
            if (cfg_index == bfsa_pkg::REG_POOL_SIZE) begin
                pool_next  = cfg_wdata;
                state_next = S_INIT;
                cnt_next   = '0;
            end else begin
                comp_en_next = cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            cnt_reg     <= '0;
            pool_reg    <= bfsa_pkg::POOL_RESET;
            comp_en_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pool_reg    <= pool_next;
            comp_en_reg <= comp_en_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg      <= m_data_next;
        t_reg           <= t_next;
        best_found_reg  <= best_found_next;
        best_size_reg   <= best_size_next;
        best_addr_reg   <= best_addr_next;
        slot_reg        <= slot_next;
        wrote_reg       <= wrote_next;
        pick_found_reg  <= pick_found_next;
        pick_addr_reg   <= pick_addr_next;
        nxt_found_reg   <= nxt_found_next;
        nxt_addr_reg    <= nxt_addr_next;
        cursor_reg      <= cursor_next;
        first_reg       <= first_next;
        a_found_reg     <= a_found_next;
        a_reg           <= a_next;
        left_reg        <= left_next;
        right_reg       <= right_next;
        rsize_reg       <= rsize_next;
        status_reg      <= status_next;
        raddr_reg       <= raddr_next;
        comp_reg        <= comp_next;
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/bfsa_cell.sv =====
// one table entry of a ring, loads its neighbor's entry on every shift
// depends on bfsa_pkg
module bfsa_cell (
    input  logic                 aclk,
    input  logic                 shift_en,
    input  bfsa_pkg::bfsa_entry_t d,
    output bfsa_pkg::bfsa_entry_t q
);

    bfsa_pkg::bfsa_entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

// ===== design/bfsa_free_ring.sv =====
// ring of free segment cells, head at cell 0, rewritten head enters at the tail
// depends on bfsa_pkg, bfsa_cell
module bfsa_free_ring (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  bfsa_pkg::bfsa_entry_t tail_d,
    output bfsa_pkg::bfsa_entry_t head_q
);

    bfsa_pkg::bfsa_entry_t q [bfsa_pkg::FREE_N];

    for (genvar i = 0; i < bfsa_pkg::FREE_N; i++) begin : g_cell
        if (i == bfsa_pkg::FREE_N - 1) begin : g_tail
            bfsa_cell u_cell (.aclk(aclk), .shift_en(shift_en), .d(tail_d), .q(q[i]));
        end else begin : g_mid
            bfsa_cell u_cell (.aclk(aclk), .shift_en(shift_en), .d(q[i+1]), .q(q[i]));
        end
    end

    assign head_q = q[0];

endmodule

// ===== design/bfsa_used_ring.sv =====
// ring of used block cells, head at cell 0, rewritten head enters at the tail
// depends on bfsa_pkg, bfsa_cell
module bfsa_used_ring (
    input  logic                  aclk,
    input  logic                  shift_en,
    input  bfsa_pkg::bfsa_entry_t tail_d,
    output bfsa_pkg::bfsa_entry_t head_q
);

    bfsa_pkg::bfsa_entry_t q [bfsa_pkg::USED_N];

    for (genvar i = 0; i < bfsa_pkg::USED_N; i++) begin : g_cell
        if (i == bfsa_pkg::USED_N - 1) begin : g_tail
            bfsa_cell u_cell (.aclk(aclk), .shift_en(shift_en), .d(tail_d), .q(q[i]));
        end else begin : g_mid
            bfsa_cell u_cell (.aclk(aclk), .shift_en(shift_en), .d(q[i+1]), .q(q[i]));
        end
    end

    assign head_q = q[0];

endmodule

// ===== design/bfsa_checker.sv =====
// port-level assertions for the allocator, bound to the top level
// depends on bfsa_pkg, best_fit_segment_allocator_core
module bfsa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input bfsa_pkg::bfsa_out_t m_data
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid && !s_ready)
        else $error("outputs active after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in work");

    a_fail_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != bfsa_pkg::ST_OK |-> m_data.address == '0)
        else $error("failed transaction with nonzero address");

    a_pack_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.compacted |->
            m_data.status == bfsa_pkg::ST_OK || m_data.status == bfsa_pkg::ST_NOFIT)
        else $error("compaction flagged on a release or full table");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule

bind best_fit_segment_allocator_core bfsa_checker u_bfsa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
